// ----- src/dlc_pkg.sv -----
// ----------------------------------------------------------------------------
// dlc_pkg: shared types and constants for the signed decimal list checker
// Field widths, action and status codes, character codes and the token that
// walks the compare chain.
// ----------------------------------------------------------------------------
`default_nettype none

package dlc_pkg;

  localparam int VAL_W  = 32;
  localparam int CH_W   = 8;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 3;
  localparam int POS_W  = 9;

  localparam int MAX_VALUES_DEF = 512;

  localparam logic [POS_W-1:0] POS_MAX = 9'd511;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CHAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_END   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NAN   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DUP   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd4;

  // character codes
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  localparam logic [VAL_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] LIMIT_NEG = 32'h8000_0000;

  // parse state of the current argument
  typedef struct packed {
    logic             bad;
    logic             ovf;
    logic [VAL_W-1:0] value;
  } dlc_scan_t;

  // query token handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             dup;
    logic [VAL_W-1:0] value;
  } dlc_tok_t;

endpackage

`default_nettype wire

// ----- src/dlc_parser.sv -----
// ----------------------------------------------------------------------------
// dlc_parser: character scanner for one argument
// Skips leading spaces, takes one sign, then accumulates decimal digits with
// saturation and flags bad text and range overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module dlc_parser
  import dlc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            char_en,
  input  wire logic            clear_en,
  input  wire logic [CH_W-1:0] ch,
  output dlc_scan_t            scan_o
);

  typedef enum logic [1:0] {
    PH_SPACES,
    PH_SIGN,
    PH_DIGITS
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [VAL_W-1:0] mag_r, mag_nxt;
  logic             bad_r, bad_nxt;
  logic             ovf_r, ovf_nxt;

  logic             is_digit;
  logic [3:0]       ch_off;
  logic [VAL_W+3:0] mag_x10;
  logic [VAL_W-1:0] mag_sat;
  logic [VAL_W-1:0] limit;

  always_comb begin
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    ch_off   = 4'(ch - CH_ZERO);
    mag_x10  = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1) + {32'b0, ch_off};
    mag_sat  = (mag_x10[VAL_W+3:VAL_W] != 4'b0) ? {VAL_W{1'b1}} : mag_x10[VAL_W-1:0];
    limit    = neg_r ? LIMIT_NEG : LIMIT_POS;

    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    bad_nxt   = bad_r;
    ovf_nxt   = ovf_r;

    if (clear_en) begin
      phase_nxt = PH_SPACES;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
      bad_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
    end else if (char_en && !bad_r) begin
      if (phase_r == PH_SPACES && ch == CH_SPACE) begin
        // drop leading space
      end else if (phase_r == PH_SPACES && (ch == CH_PLUS || ch == CH_MINUS)) begin
        neg_nxt   = (ch == CH_MINUS);
        phase_nxt = PH_SIGN;
      end else if (!is_digit) begin
        bad_nxt = 1'b1;
      end else begin
        phase_nxt = PH_DIGITS;
        mag_nxt   = mag_sat;
        if (mag_sat > limit) begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACES;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      bad_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      bad_r   <= bad_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign scan_o.bad   = bad_r;
  assign scan_o.ovf   = ovf_r;
  assign scan_o.value = neg_r ? (32'd0 - mag_r) : mag_r;

endmodule

`default_nettype wire

// ----- src/dlc_cell.sv -----
// ----------------------------------------------------------------------------
// dlc_cell: one compare cell of the value chain
// Holds one stored value, checks the passing query against it and hands the
// query on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module dlc_cell
  import dlc_pkg::*;
#(
  parameter int MAX_VALUES = MAX_VALUES_DEF,
  parameter int CELL_IDX   = 0
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire dlc_tok_t                        tok_i,
  output dlc_tok_t                             tok_o,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(MAX_VALUES)-1:0]   wr_idx,
  input  wire logic [VAL_W-1:0]                wr_value,
  input  wire logic [$clog2(MAX_VALUES+1)-1:0] count
);

  localparam int CNT_W = $clog2(MAX_VALUES + 1);
  localparam int IDX_W = $clog2(MAX_VALUES);

  logic [VAL_W-1:0] value_r;
  dlc_tok_t         tok_r, tok_nxt;
  logic             occupied;

  always_comb begin
    occupied    = count > CNT_W'(CELL_IDX);
    tok_nxt     = tok_i;
    tok_nxt.dup = tok_i.dup | (occupied && (value_r == tok_i.value));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.dup   <= tok_nxt.dup;
    tok_r.value <= tok_nxt.value;
    if (wr_en && wr_idx == IDX_W'(CELL_IDX)) begin
      value_r <= wr_value;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// ----- src/dlc_chain.sv -----
// ----------------------------------------------------------------------------
// dlc_chain: row of compare cells
// The query enters at cell 0 and advances one cell per cycle; the last cell
// delivers it with the duplicate flag gathered along the way.
// ----------------------------------------------------------------------------
`default_nettype none

module dlc_chain
  import dlc_pkg::*;
#(
  parameter int MAX_VALUES = MAX_VALUES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire dlc_tok_t                        tok_i,
  output dlc_tok_t                             tok_o,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(MAX_VALUES)-1:0]   wr_idx,
  input  wire logic [VAL_W-1:0]                wr_value,
  input  wire logic [$clog2(MAX_VALUES+1)-1:0] count
);

  dlc_tok_t link [0:MAX_VALUES];

  assign link[0] = tok_i;

  for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
    dlc_cell #(
      .MAX_VALUES (MAX_VALUES),
      .CELL_IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (link[i]),
      .tok_o    (link[i+1]),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_value (wr_value),
      .count    (count)
    );
  end

  assign tok_o = link[MAX_VALUES];

endmodule

`default_nettype wire

// ----- src/signed_decimal_list_checker_core.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_list_checker_core: decimal argument parser with duplicate check
// Parses signed decimal text arguments beat by beat and checks each accepted
// value against the values already kept in the current list.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry in_action (character, end of argument, clear list) and
//   in_ch. Character beats give no result.
//   An end-of-argument beat gives exactly one result beat (status, value,
//   position). Bad text or an out-of-range value is answered in the next
//   cycle. A well-formed value is registered as a query and sent down the row
//   of MAX_VALUES compare cells, one cell per cycle; its result is registered
//   in the output register as it leaves the last cell, so the length of the
//   cell row sets how long that takes. In_stall stays high during that walk.
//   An end-of-argument beat is held off while an earlier result still sits in
//   the output register; character and clear beats keep flowing meanwhile.
//   A stalled result holds its payload until taken.
//   Reset empties the list, zeroes the argument counter and the scan state.
//   Cell contents have no reset: a cell is only compared once written.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_list_checker_core
  import dlc_pkg::*;
#(
  parameter int MAX_VALUES = MAX_VALUES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [ACT_W-1:0]         in_action,
  input  wire logic [CH_W-1:0]          in_ch,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [STAT_W-1:0]             out_status,
  output logic signed [VAL_W-1:0]       out_value,
  output logic [POS_W-1:0]              out_position
);

  localparam int CNT_W = $clog2(MAX_VALUES + 1);
  localparam int IDX_W = $clog2(MAX_VALUES);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [POS_W-1:0]  out_position_r, out_position_nxt;
  logic [POS_W-1:0]  pos_hold_r, pos_hold_nxt;
  logic [POS_W-1:0]  arg_count_r, arg_count_nxt;
  logic [CNT_W-1:0]  stored_count_r, stored_count_nxt;
  dlc_tok_t          launch_r, launch_nxt;

  logic      accept;
  logic      is_char, is_end, is_clear;
  dlc_scan_t scan;
  dlc_tok_t  tok_last;
  logic      wr_en;
  logic      store_full;

  // Hold off an end beat while a result still waits; stall everything while
  // the query walks the cell row.
  assign in_stall = (state_r == S_SEARCH) || (in_action == ACT_END && out_valid_r);
  assign accept   = in_valid && !in_stall;
  assign is_char  = accept && (in_action == ACT_CHAR);
  assign is_end   = accept && (in_action == ACT_END);
  assign is_clear = accept && (in_action == ACT_CLEAR);

  dlc_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .char_en  (is_char),
    .clear_en (is_end || is_clear),
    .ch       (in_ch),
    .scan_o   (scan)
  );

  dlc_chain #(
    .MAX_VALUES (MAX_VALUES)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_i    (launch_r),
    .tok_o    (tok_last),
    .wr_en    (wr_en),
    .wr_idx   (stored_count_r[IDX_W-1:0]),
    .wr_value (tok_last.value),
    .count    (stored_count_r)
  );

  assign store_full = (stored_count_r == CNT_W'(MAX_VALUES));
  // Store a new value into the first free cell once the walk found no match.
  assign wr_en      = tok_last.vld && !tok_last.dup && !store_full;

  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_value_nxt    = out_value_r;
    out_position_nxt = out_position_r;
    pos_hold_nxt     = pos_hold_r;
    arg_count_nxt    = arg_count_r;
    stored_count_nxt = stored_count_r;
    launch_nxt.vld   = 1'b0;
    launch_nxt.dup   = 1'b0;
    launch_nxt.value = scan.value;

    case (state_r)
      S_IDLE: begin
        if (is_clear) begin
          stored_count_nxt = '0;
          arg_count_nxt    = '0;
        end else if (is_end) begin
          if (arg_count_r != POS_MAX) begin
            arg_count_nxt = arg_count_r + 1'b1;
          end
          if (scan.bad || scan.ovf) begin
            // Bad text wins over overflow; answer at once.
            out_valid_nxt    = 1'b1;
            out_status_nxt   = scan.bad ? STAT_NAN : STAT_RANGE;
            out_value_nxt    = '0;
            out_position_nxt = arg_count_r;
          end else begin
            launch_nxt.vld = 1'b1;
            pos_hold_nxt   = arg_count_r;
            state_nxt      = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (tok_last.vld) begin
          out_valid_nxt    = 1'b1;
          out_position_nxt = pos_hold_r;
          state_nxt        = S_IDLE;
          if (tok_last.dup) begin
            out_status_nxt = STAT_DUP;
            out_value_nxt  = tok_last.value;
          end else if (store_full) begin
            out_status_nxt = STAT_FULL;
            out_value_nxt  = '0;
          end else begin
            out_status_nxt   = STAT_OK;
            out_value_nxt    = tok_last.value;
            stored_count_nxt = stored_count_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      arg_count_r    <= '0;
      stored_count_r <= '0;
      launch_r.vld   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      arg_count_r    <= arg_count_nxt;
      stored_count_r <= stored_count_nxt;
      launch_r.vld   <= launch_nxt.vld;
    end
    launch_r.dup   <= launch_nxt.dup;
    launch_r.value <= launch_nxt.value;
    out_status_r   <= out_status_nxt;
    out_value_r    <= out_value_nxt;
    out_position_r <= out_position_nxt;
    pos_hold_r     <= pos_hold_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_value    = $signed(out_value_r);
  assign out_position = out_position_r;

endmodule

`default_nettype wire
